// File: rtl/sfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int unsigned MAX_BURST       = 16;
    localparam int unsigned BURST_CNT_W     = $clog2(MAX_BURST + 1);
    localparam int unsigned DEF_MAX_PATTERN = 16;
    localparam int unsigned LEN_W           = 5;
    localparam int unsigned CFG_DATA_W      = 64;
    localparam int unsigned CFG_INDEX_W     = 3;

    typedef logic [7:0] byte_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW        = 3'd0,
        REG_PATTERN_HIGH       = 3'd1,
        REG_PATTERN_LENGTH     = 3'd2,
        REG_REPLACEMENT_LOW    = 3'd3,
        REG_REPLACEMENT_HIGH   = 3'd4,
        REG_REPLACEMENT_LENGTH = 3'd5
    } cfg_index_t;

    // register contents as seen by the datapath
    typedef struct packed {
        byte_t [MAX_BURST-1:0]   pattern;
        logic  [LEN_W-1:0]       pattern_length;
        byte_t [MAX_BURST-1:0]   replacement;
        logic  [BURST_CNT_W-1:0] replacement_length;
    } cfg_t;

    // group of result words produced by one input word
    typedef struct packed {
        byte_t [MAX_BURST-1:0]   data;
        logic  [BURST_CNT_W-1:0] count;
        logic                    last;
        logic                    bare;
    } burst_t;

endpackage
`default_nettype wire

// File: rtl/sfr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels of the streaming find-and-replace block.
// ----------------------------------------------------------------------------
interface sfr_in_if import sfr_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  has_byte;
    logic  out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/sfr_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_cfg
// Configuration register file: pattern, replacement and their lengths.
// ----------------------------------------------------------------------------
module sfr_cfg import sfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfr_cfg_if.sink    cfg,
    output cfg_t       settings
);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] rep_low_reg;
    logic [CFG_DATA_W-1:0] rep_high_reg;
    logic [LEN_W-1:0]      rep_len_reg;
    logic                  wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_W'(1);
            rep_low_reg  <= '0;
            rep_high_reg <= '0;
            rep_len_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_PATTERN_LOW:        pat_low_reg  <= cfg.data;
                REG_PATTERN_HIGH:       pat_high_reg <= cfg.data;
                REG_PATTERN_LENGTH:     pat_len_reg  <= cfg.data[LEN_W-1:0];
                REG_REPLACEMENT_LOW:    rep_low_reg  <= cfg.data;
                REG_REPLACEMENT_HIGH:   rep_high_reg <= cfg.data;
                REG_REPLACEMENT_LENGTH: rep_len_reg  <= cfg.data[LEN_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        settings.pattern        = {pat_high_reg, pat_low_reg};
        settings.pattern_length = pat_len_reg;
        settings.replacement    = {rep_high_reg, rep_low_reg};
        // replacement length saturates at the burst size
        if (rep_len_reg > LEN_W'(MAX_BURST))
            settings.replacement_length = BURST_CNT_W'(MAX_BURST);
        else
            settings.replacement_length = BURST_CNT_W'(rep_len_reg);
    end

endmodule
`default_nettype wire

// File: rtl/sfr_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_window
// Input register, match window and parallel compare; builds one burst
// of result words per input word.
// ----------------------------------------------------------------------------
module sfr_window import sfr_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfr_in_if.sink     item,
    input  wire cfg_t  settings,
    input  wire logic  burst_ready,
    output logic       burst_load,
    output burst_t     burst
);

    localparam int unsigned WIN_DEPTH = (MAX_PATTERN < MAX_BURST) ? MAX_PATTERN : MAX_BURST;
    localparam int unsigned CNT_W     = $clog2(WIN_DEPTH + 1);

    logic                  hold_valid_reg;
    byte_t                 hold_byte_reg;
    logic                  hold_last_reg;

    byte_t [WIN_DEPTH-1:0] win_reg;
    byte_t [WIN_DEPTH-1:0] win_next;
    logic  [CNT_W-1:0]     count_reg;
    logic  [CNT_W-1:0]     count_next;

    logic  [CNT_W-1:0]     len;
    logic  [CNT_W-1:0]     c0;
    logic  [CNT_W-1:0]     c1;
    byte_t [WIN_DEPTH-1:0] w;
    byte_t [MAX_BURST-1:0] wpad;
    logic                  full;
    logic                  match;
    logic                  hit;

    assign burst_load = hold_valid_reg && burst_ready;
    assign item.ready = !hold_valid_reg || burst_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (item.valid && item.ready)
            hold_valid_reg <= 1'b1;
        else if (burst_load)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            hold_byte_reg <= item.in_byte;
            hold_last_reg <= item.in_last;
        end
    end

    always_comb
    begin
        // effective pattern length: zero counts as one, longer lengths are clamped to the window
        if (settings.pattern_length == '0)
            len = CNT_W'(1);
        else if (settings.pattern_length > LEN_W'(WIN_DEPTH))
            len = CNT_W'(WIN_DEPTH);
        else
            len = CNT_W'(settings.pattern_length);

        // stale bytes from a shortened pattern are dropped
        c0 = (count_reg >= len) ? '0 : count_reg;
        c1 = c0 + CNT_W'(1);

        for (int i = 0; i < WIN_DEPTH; i++)
            w[i] = (CNT_W'(i) == c0) ? hold_byte_reg : win_reg[i];

        full  = (c1 == len);
        match = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if (CNT_W'(i) < len && w[i] != settings.pattern[i])
                match = 1'b0;
        end
        hit = full && match;

        wpad = '0;
        for (int i = 0; i < WIN_DEPTH; i++)
            wpad[i] = w[i];

        // a miss on a full window emits the oldest byte; on the final word the whole window goes
        burst.data = hit ? settings.replacement : wpad;
        burst.last = hold_last_reg;
        burst.bare = 1'b0;
        if (hit)
            burst.count = settings.replacement_length;
        else if (hold_last_reg)
            burst.count = BURST_CNT_W'(c1);
        else if (full)
            burst.count = BURST_CNT_W'(1);
        else
            burst.count = '0;

        // nothing left for the final word: bare end marker
        if (hold_last_reg && burst.count == '0)
        begin
            burst.data[0] = 8'h00;
            burst.count   = BURST_CNT_W'(1);
            burst.bare    = 1'b1;
        end

        win_next = w;
        if (hit || hold_last_reg)
            count_next = '0;
        else if (full)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
                win_next[i] = w[i + 1];
            count_next = c0;
        end
        else
            count_next = c1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (burst_load)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (burst_load)
            win_reg <= win_next;
    end

endmodule
`default_nettype wire

// File: rtl/sfr_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_emit
// Result register: holds one burst and shifts it out a word per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module sfr_emit import sfr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire burst_t burst,
    input  wire logic   burst_load,
    output logic        burst_ready,
    sfr_out_if.source   result
);

    byte_t [MAX_BURST-1:0]   data_reg;
    byte_t [MAX_BURST-1:0]   data_next;
    logic  [BURST_CNT_W-1:0] left_reg;
    logic  [BURST_CNT_W-1:0] left_next;
    logic                    last_reg;
    logic                    bare_reg;
    logic                    take;

    assign take            = result.valid && result.ready;
    assign burst_ready     = (left_reg == '0) || (take && left_reg == BURST_CNT_W'(1));
    assign result.valid    = (left_reg != '0);
    assign result.out_byte = data_reg[0];
    assign result.has_byte = !bare_reg;
    assign result.out_last = last_reg && (left_reg == BURST_CNT_W'(1));

    always_comb
    begin
        data_next = data_reg;
        left_next = left_reg;
        if (burst_load)
        begin
            data_next = burst.data;
            left_next = burst.count;
        end
        else if (take)
        begin
            data_next = data_reg >> 8;
            left_next = left_reg - BURST_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else
            left_reg <= left_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (burst_load)
        begin
            last_reg <= burst.last;
            bare_reg <= burst.bare;
        end
    end

endmodule
`default_nettype wire

// File: rtl/stream_find_replace.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace over a byte stream.
// ----------------------------------------------------------------------------
// Channels: item takes one byte per word with in_last on the buffer's final
// byte; result gives out_byte, has_byte and out_last; cfg writes the pattern,
// the replacement and their lengths by register index. The user must do so
// only while the block idles, which it does not enforce. Non-overlapping
// matches of the pattern are replaced; other bytes pass through in order once
// they can no longer start a match. On the final byte the window is flushed
// and the last word carries out_last, or a bare end marker (has_byte low) is
// sent if the final byte leaves nothing to send. A word accepted into the
// input register is compared there, and its results go to the result
// register, which offers them. Throughput: one word per cycle while each byte
// gives at most one result and the receiver is ready; a byte that completes a
// match occupies the result register until its replacement bytes are taken,
// and the input register takes one more word meanwhile. Reset clears the
// window and all control state and loads the register defaults; no clearing
// pass is needed. When the receiver stalls, the result word holds and the
// input backs up after one word.
// ----------------------------------------------------------------------------
module stream_find_replace import sfr_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = DEF_MAX_PATTERN
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfr_in_if.sink     item,
    sfr_out_if.source  result,
    sfr_cfg_if.sink    cfg
);

    cfg_t   settings;
    burst_t burst;
    logic   burst_load;
    logic   burst_ready;

    sfr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    sfr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .settings    (settings),
        .burst_ready (burst_ready),
        .burst_load  (burst_load),
        .burst       (burst)
    );

    sfr_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .burst_load  (burst_load),
        .burst_ready (burst_ready),
        .result      (result)
    );

    // an end marker is always a single, final word
    a_bare_final: assert property (@(posedge clk) disable iff (!rst_n)
        burst_load && burst.bare |-> burst.last && burst.count == BURST_CNT_W'(1))
        else $error("bare end marker not alone or not final");

    a_burst_size: assert property (@(posedge clk) disable iff (!rst_n)
        burst_load |-> burst.count <= BURST_CNT_W'(MAX_BURST))
        else $error("burst longer than result register");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.has_byte |-> result.out_last)
        else $error("byte-less word without out_last");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
// A clocked driver feeds byte words from a pending queue. A rewrite predictor
// follows every accepted word and keeps the result words it should cause.
// A clocked monitor checks each result word against the oldest of those.
// Directed buffers cover deletion, partial matches at the buffer end, length
// saturation and a pattern length lowered inside a buffer. Random buffers
// follow, built mostly from pattern occurrences, under several register
// settings and under sender and receiver idling, with one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb_top import sfr_pkg::*; ();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int PATTERN_CAP   = (DEF_MAX_PATTERN < MAX_BURST) ? DEF_MAX_PATTERN : MAX_BURST;

    typedef struct packed {
        byte_t data;
        logic  last;
    } in_word_t;

    typedef struct packed {
        byte_t data;
        logic  has;
        logic  last;
    } out_word_t;

    logic clk;
    logic rst_n;

    sfr_in_if  in_bus ();
    sfr_out_if out_bus ();
    sfr_cfg_if cfg_bus ();

    stream_find_replace dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_bus),
        .result (out_bus),
        .cfg    (cfg_bus)
    );

    // register shadow
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic [63:0] rep_lo;
    logic [63:0] rep_hi;
    logic [4:0]  rep_len;

    // rewrite window
    byte_t win_bytes [MAX_BURST];
    int    win_count;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];
    in_word_t  next_word;
    out_word_t want;

    bit in_taken;
    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int mismatches;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic byte_t pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                        input int idx);
        logic [127:0] both;
        both = {hi, lo};
        return both[8*idx +: 8];
    endfunction

    function automatic int eff_pat_len();
        if (pat_len == 0)
            return 1;
        if (pat_len > PATTERN_CAP)
            return PATTERN_CAP;
        return pat_len;
    endfunction

    // advances the window by one byte and queues the words it gives
    task automatic rewrite_byte(input byte_t b, input logic last);
        int  len;
        int  rl;
        int  n;
        bit  hit;
        len = eff_pat_len();
        n = 0;
        if (win_count >= len)
            win_count = 0;  // stale bytes after a shorter pattern length
        win_bytes[win_count] = b;
        win_count++;
        if (win_count == len)
        begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (win_bytes[i] != pick_byte(pat_lo, pat_hi, i))
                    hit = 1'b0;
            if (hit)
            begin
                rl = (rep_len > MAX_BURST) ? MAX_BURST : rep_len;
                for (int i = 0; i < rl; i++)
                    expected_words.push_back('{pick_byte(rep_lo, rep_hi, i), 1'b1, 1'b0});
                n += rl;
                win_count = 0;
            end
            else
            begin
                expected_words.push_back('{win_bytes[0], 1'b1, 1'b0});
                n++;
                for (int i = 0; i < MAX_BURST - 1; i++)
                    win_bytes[i] = win_bytes[i+1];
                win_count--;
            end
        end
        if (last)
        begin
            for (int i = 0; i < win_count; i++)
                expected_words.push_back('{win_bytes[i], 1'b1, 1'b0});
            n += win_count;
            win_count = 0;
            if (n == 0)
                expected_words.push_back('{8'h00, 1'b0, 1'b0});
            expected_words[$].last = 1'b1;
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_PATTERN_LOW:        pat_lo  = value;
            REG_PATTERN_HIGH:       pat_hi  = value;
            REG_PATTERN_LENGTH:     pat_len = value[4:0];
            REG_REPLACEMENT_LOW:    rep_lo  = value;
            REG_REPLACEMENT_HIGH:   rep_hi  = value;
            REG_REPLACEMENT_LENGTH: rep_len = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic push_word(input byte_t b, input logic last);
        pending_words.push_back('{b, last});
    endtask

    // all words sent, all results back, then a settling wait for a byte-less tail
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_bus.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // kind 0: random, 1: longest pattern and replacement, 2: deletion
    task automatic setup_random(input int kind);
        logic [127:0] p;
        int           r;
        logic [4:0]   plen;
        logic [4:0]   rlen;
        for (int i = 0; i < 16; i++)
            p[8*i +: 8] = $urandom_range(1) ? 8'($urandom_range(8'h64, 8'h61))
                                            : 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 60)
            plen = 5'($urandom_range(4, 1));
        else if (r < 80)
            plen = 5'($urandom_range(16, 5));
        else if (r < 90)
            plen = 5'd0;
        else
            plen = 5'($urandom_range(31, 17));
        rlen = $urandom_range(99) < 85 ? 5'($urandom_range(16))
                                       : 5'($urandom_range(31, 17));
        if (kind == 1)
        begin
            plen = 5'd16;
            rlen = 5'd16;
        end
        else if (kind == 2)
        begin
            plen = 5'($urandom_range(3, 1));
            rlen = 5'd0;
        end
        write_reg(REG_PATTERN_LOW, p[63:0]);
        write_reg(REG_PATTERN_HIGH, p[127:64]);
        write_reg(REG_PATTERN_LENGTH, 64'(plen));
        write_reg(REG_REPLACEMENT_LOW, rand64());
        write_reg(REG_REPLACEMENT_HIGH, rand64());
        write_reg(REG_REPLACEMENT_LENGTH, 64'(rlen));
    endtask

    // buffers made mostly of pattern occurrences, some cut short or corrupted
    task automatic queue_random_stream(input int total);
        int    left;
        int    blen;
        int    len;
        int    cut;
        int    k;
        byte_t b;
        left = total;
        while (left > 0)
        begin
            len = eff_pat_len();
            blen = $urandom_range(len + 12, 1);
            if (blen > left)
                blen = left;
            k = 0;
            while (k < blen)
            begin
                if ($urandom_range(99) < 45)
                begin
                    cut = ($urandom_range(99) < 20) ? $urandom_range(len, 1) : len;
                    for (int j = 0; j < cut && k < blen; j++)
                    begin
                        b = pick_byte(pat_lo, pat_hi, j);
                        if (cut == len && $urandom_range(99) < 5)
                            b ^= 8'(1 << $urandom_range(7));
                        push_word(b, k == blen - 1);
                        k++;
                    end
                end
                else
                begin
                    if ($urandom_range(99) < 60)
                        b = pick_byte(pat_lo, pat_hi, $urandom_range(15));
                    else
                        b = 8'($urandom_range(255));
                    push_word(b, k == blen - 1);
                    k++;
                end
            end
            left -= blen;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            rewrite_byte(in_bus.in_byte, in_bus.in_last);
            in_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_bus.valid <= 1'b0;
        else if (!in_bus.valid || in_taken)
        begin
            in_taken = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_word = pending_words.pop_front();
                in_bus.valid   <= 1'b1;
                in_bus.in_byte <= next_word.data;
                in_bus.in_last <= next_word.last;
            end
            else
                in_bus.valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_left != 0)
            out_bus.ready <= 1'b0;
        else
            out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: byte %02h has %0d last %0d",
                             out_bus.out_byte, out_bus.has_byte, out_bus.out_last);
            end
            else
            begin
                want = expected_words.pop_front();
                if (out_bus.out_byte !== want.data || out_bus.has_byte !== want.has ||
                    out_bus.out_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: exp %02h/%0d/%0d got %02h/%0d/%0d",
                                 want.data, want.has, want.last,
                                 out_bus.out_byte, out_bus.has_byte, out_bus.out_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int send_plan [4];
        int stall_plan [4];
        send_plan  = '{0, 84, 0, 37};
        stall_plan = '{0, 0, 84, 37};

        rst_n = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.in_byte = 8'h00;
        in_bus.in_last = 1'b0;
        out_bus.ready  = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = REG_PATTERN_LOW;
        cfg_bus.data   = '0;
        in_taken = 1'b0;
        send_idle_pct = 30;
        stall_pct = 30;
        hold_left = 0;
        mismatches = 0;
        cycle_count = 0;
        win_count = 0;
        pat_lo = '0;
        pat_hi = '0;
        pat_len = 5'd1;
        rep_lo = '0;
        rep_hi = '0;
        rep_len = 5'd0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // register defaults delete every zero byte
        push_word(8'h00, 1'b1);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);
        wait_idle();

        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0043_4241);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_REPLACEMENT_LOW, 64'h0000_0000_0000_7A79);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
        push_word(8'h41, 1'b0);
        push_word(8'h42, 1'b0);
        push_word(8'h43, 1'b0);
        push_word(8'h80, 1'b1);
        // partial match cut off by the buffer end
        push_word(8'h41, 1'b0);
        push_word(8'h42, 1'b1);
        // match completed by the final byte
        push_word(8'h41, 1'b0);
        push_word(8'h41, 1'b0);
        push_word(8'h42, 1'b0);
        push_word(8'h43, 1'b1);
        // pattern shortened while the window holds bytes
        push_word(8'h10, 1'b0);
        push_word(8'h11, 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        push_word(8'h41, 1'b0);
        push_word(8'h20, 1'b1);
        wait_idle();

        // zero pattern length acts as one, oversized replacement saturates
        write_reg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_REPLACEMENT_LOW, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_REPLACEMENT_HIGH, 64'hFEDC_BA98_7654_3210);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd31);
        push_word(8'hFF, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h7F, 1'b1);
        wait_idle();

        // oversized pattern saturates, nothing matches before the end
        write_reg(REG_PATTERN_LENGTH, 64'd31);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
        push_word(8'hFF, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int sub = 0; sub < 2; sub++)
            begin
                send_idle_pct = 0;
                stall_pct = 0;
                if (ph == 0 && sub == 0)
                    setup_random(1);
                else if (ph == 1 && sub == 1)
                    setup_random(2);
                else
                    setup_random(0);
                send_idle_pct = send_plan[ph];
                stall_pct = stall_plan[ph];
                if (ph == 0 && sub == 0)
                    hold_left = 400;  // back the block up against its input
                queue_random_stream(26);
                wait_idle();
            end
        end

        if (mismatches == 0 && expected_words.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/sfr_cfg.sv
rtl/sfr_window.sv
rtl/sfr_emit.sv
rtl/stream_find_replace.sv
bench/tb_top.sv
